/* hdl/cse_pkg.sv */
// Shared types and constants for the gas sensor frame engine.
// Used by cse_front, cse_queue, cse_back and co2_sensor_frame_engine.
package cse_pkg;

    // Input commands
    localparam logic [2:0] CMD_MEASURE = 3'd0;
    localparam logic [2:0] CMD_ZERO    = 3'd1;
    localparam logic [2:0] CMD_SPAN    = 3'd2;
    localparam logic [2:0] CMD_RX_BYTE = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_OK      = 2'd1;
    localparam logic [1:0] KIND_CSUM    = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT = 2'd3;

    // Frame bytes
    localparam logic [7:0] FRAME_START = 8'hFF;
    localparam logic [7:0] FRAME_ADDR  = 8'h01;
    localparam logic [7:0] OP_MEASURE  = 8'h86;
    localparam logic [7:0] OP_ZERO     = 8'h87;
    localparam logic [7:0] OP_SPAN     = 8'h88;

    localparam logic [3:0]  FRAME_LAST_IDX   = 4'd8;
    localparam logic [3:0]  REPLY_LAST_IDX   = 4'd8;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd100;
    localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

    // One unit of work for the back end: a full frame or a single report
    typedef struct packed {
        logic        is_frame;
        logic [7:0]  op;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [7:0]  chk;
        logic [1:0]  kind;
        logic [16:0] conc;
    } t_job;

endpackage

/* hdl/cse_front.sv */
// Front end: accepts commands, tracks reply reception and timeout,
// and emits one job per command that produces results. Uses cse_pkg.
module cse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_command,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_span_high,
    input  logic [7:0]        i_span_low,
    input  logic              i_cfg_write,
    input  logic [15:0]       i_cfg_data,
    output logic              o_push,
    output cse_pkg::t_job     o_job
);

    logic        r_waiting,  n_waiting;
    logic [3:0]  r_count,    n_count;
    logic [7:0]  r_sum,      n_sum;
    logic [7:0]  r_vhigh,    n_vhigh;
    logic [7:0]  r_vlow,     n_vlow;
    logic [15:0] r_elapsed,  n_elapsed;
    logic [15:0] r_timeout;

    logic [7:0]  w_expect;
    logic [15:0] w_tick_next;
    logic        w_has_job;

    // Hold the timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= cse_pkg::TIMEOUT_RESET;
        end else if (i_cfg_write) begin
            r_timeout <= i_cfg_data;
        end
    end

    assign w_expect    = 8'd0 - r_sum;
    assign w_tick_next = (r_elapsed == cse_pkg::TICKS_MAX) ? r_elapsed : r_elapsed + 16'd1;

    // Classify the transaction and compute next reception state
    always_comb begin
        n_waiting = r_waiting;
        n_count   = r_count;
        n_sum     = r_sum;
        n_vhigh   = r_vhigh;
        n_vlow    = r_vlow;
        n_elapsed = r_elapsed;
        w_has_job = 1'b0;
        o_job.is_frame = 1'b0;
        o_job.op       = cse_pkg::OP_MEASURE;
        o_job.b3       = 8'd0;
        o_job.b4       = 8'd0;
        o_job.kind     = cse_pkg::KIND_TX;
        o_job.conc     = 17'd0;
        case (i_command)
            cse_pkg::CMD_MEASURE: begin
                n_waiting = 1'b1;
                n_count   = 4'd0;
                n_sum     = 8'd0;
                n_vhigh   = 8'd0;
                n_vlow    = 8'd0;
                n_elapsed = 16'd0;
                w_has_job = 1'b1;
                o_job.is_frame = 1'b1;
            end
            cse_pkg::CMD_ZERO: begin
                w_has_job = 1'b1;
                o_job.is_frame = 1'b1;
                o_job.op       = cse_pkg::OP_ZERO;
            end
            cse_pkg::CMD_SPAN: begin
                w_has_job = 1'b1;
                o_job.is_frame = 1'b1;
                o_job.op       = cse_pkg::OP_SPAN;
                o_job.b3       = i_span_high;
                o_job.b4       = i_span_low;
            end
            cse_pkg::CMD_RX_BYTE: begin
                if (r_waiting) begin
                    if (r_count >= 4'd1 && r_count <= 4'd7) begin
                        n_sum = r_sum + i_rx_byte;
                    end
                    if (r_count == 4'd2) begin
                        n_vhigh = i_rx_byte;
                    end
                    if (r_count == 4'd3) begin
                        n_vlow = i_rx_byte;
                    end
                    if (r_count >= cse_pkg::REPLY_LAST_IDX) begin
                        // Checksum byte: report and go idle
                        n_waiting = 1'b0;
                        n_count   = 4'd0;
                        w_has_job = 1'b1;
                        if (i_rx_byte == w_expect) begin
                            o_job.kind = cse_pkg::KIND_OK;
                            o_job.conc = {1'b0, r_vhigh, r_vlow};
                        end else begin
                            o_job.kind = cse_pkg::KIND_CSUM;
                            o_job.conc = '1;
                        end
                    end else begin
                        n_count = r_count + 4'd1;
                    end
                end
            end
            cse_pkg::CMD_TICK: begin
                if (r_waiting) begin
                    n_elapsed = w_tick_next;
                    if (w_tick_next > r_timeout) begin
                        n_waiting  = 1'b0;
                        n_count    = 4'd0;
                        w_has_job  = 1'b1;
                        o_job.kind = cse_pkg::KIND_TIMEOUT;
                    end
                end
            end
            default: begin
                w_has_job = 1'b0;
            end
        endcase
        // Frame checksum: negated sum of bytes 1 to 7 (bytes 5 to 7 are zero)
        o_job.chk = 8'd0 - (cse_pkg::FRAME_ADDR + o_job.op + o_job.b3 + o_job.b4);
    end

    assign o_push = i_accept && w_has_job;

    // Advance reception state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            r_count   <= 4'd0;
            r_sum     <= 8'd0;
            r_vhigh   <= 8'd0;
            r_vlow    <= 8'd0;
            r_elapsed <= 16'd0;
        end else if (i_accept) begin
            r_waiting <= n_waiting;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_vhigh   <= n_vhigh;
            r_vlow    <= n_vlow;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

/* hdl/cse_queue.sv */
// Job queue between front and back end of the frame engine.
// Small circular buffer of cse_pkg::t_job entries.
module cse_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cse_pkg::t_job     i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_head_valid,
    output cse_pkg::t_job     o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cse_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    // Store pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* hdl/cse_back.sv */
// Back end: expands queued jobs into result transactions and holds
// them in an output register. Uses cse_pkg.
module cse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  cse_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_tx_byte,
    output logic signed [16:0] o_concentration,
    output logic               o_last
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_tx;
    logic [16:0] r_conc;
    logic        r_last;
    logic [3:0]  r_idx;

    logic       w_load;
    logic [7:0] w_byte;
    logic       w_frame_end;

    assign w_load      = i_head_valid && (!r_valid || i_ready);
    assign w_frame_end = (r_idx == cse_pkg::FRAME_LAST_IDX);
    assign o_pop       = w_load && (!i_head.is_frame || w_frame_end);

    // Select the frame byte at the current position
    always_comb begin
        case (r_idx)
            4'd0:    w_byte = cse_pkg::FRAME_START;
            4'd1:    w_byte = cse_pkg::FRAME_ADDR;
            4'd2:    w_byte = i_head.op;
            4'd3:    w_byte = i_head.b3;
            4'd4:    w_byte = i_head.b4;
            4'd8:    w_byte = i_head.chk;
            default: w_byte = 8'd0;
        endcase
    end

    // Load the output register and step through the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                if (i_head.is_frame) begin
                    r_idx <= w_frame_end ? 4'd0 : r_idx + 4'd1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (i_head.is_frame) begin
                r_kind <= cse_pkg::KIND_TX;
                r_tx   <= w_byte;
                r_conc <= 17'd0;
                r_last <= w_frame_end;
            end else begin
                r_kind <= i_head.kind;
                r_tx   <= 8'd0;
                r_conc <= i_head.conc;
                r_last <= 1'b1;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_tx_byte       = r_tx;
    assign o_concentration = signed'(r_conc);
    assign o_last          = r_last;

endmodule

/* hdl/co2_sensor_frame_engine.sv */
// Top level of the serial gas sensor frame engine.
// Instantiates cse_front, cse_queue and cse_back; uses cse_pkg.
//
// The block takes one command transaction per cycle while its job queue
// has room. Measure, zero and span commands each produce a 9-byte frame
// (FF 01 op b3 b4 00 00 00 checksum) delivered as nine results at one
// per cycle while i_ready holds; the last byte carries o_last. Received
// bytes and ticks are handled in the cycle they are accepted and produce
// at most one report (measurement, checksum error with concentration -1,
// or timeout). Results leave through a registered output at one per
// cycle while i_ready holds; the QUEUE_DEPTH-entry queue lets commands
// keep arriving while a frame is sent, and o_ready drops only when it is
// full. The timeout register is written through the cfg channel, which is
// always ready, and resets to 100 ticks.
module co2_sensor_frame_engine #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [7:0]         i_rx_byte,
    input  logic [7:0]         i_span_high,
    input  logic [7:0]         i_span_low,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_tx_byte,
    output logic signed [16:0] o_concentration,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    logic          w_full;
    logic          w_push;
    logic          w_pop;
    logic          w_head_valid;
    cse_pkg::t_job w_job;
    cse_pkg::t_job w_head;

    assign o_ready     = !w_full;
    assign o_cfg_ready = 1'b1;

    // Classify commands and track reception
    cse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_valid && !w_full),
        .i_command   (i_command),
        .i_rx_byte   (i_rx_byte),
        .i_span_high (i_span_high),
        .i_span_low  (i_span_low),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    // Buffer jobs between the two halves
    cse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_job        (w_job),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Expand jobs into result transactions
    cse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_concentration (o_concentration),
        .o_last          (o_last)
    );

endmodule
